FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/tbpd_pkg.sv
package tbpd_pkg;

	localparam int OP_W     = 2;
	localparam int GROUP_W  = 3;
	localparam int TAXEL_W  = 6;
	localparam int SAMPLE_W = 16;
	localparam int THRESH_W = 16;
	localparam int SUM_W    = 21;
	localparam int REGION_W = 2;

	localparam int GROUP_COUNT   = 6;
	localparam int THRESH_RESET  = 200;

	localparam logic [OP_W-1:0] OP_BASE_FIRST = 2'd0;
	localparam logic [OP_W-1:0] OP_BASE_ACC   = 2'd1;
	localparam logic [OP_W-1:0] OP_DETECT     = 2'd2;
	localparam logic [OP_W-1:0] OP_IGNORED    = 2'd3;

	localparam logic [GROUP_W-1:0] PALM_GROUP = 3'd5;

	localparam logic [REGION_W-1:0] REGION_PALM_UPPER = 2'd0;
	localparam logic [REGION_W-1:0] REGION_PALM_LOWER = 2'd1;
	localparam logic [REGION_W-1:0] REGION_PALM2      = 2'd2;
	localparam logic [REGION_W-1:0] REGION_FINGER     = 2'd3;

	localparam int Q_DEPTH = 2;

	// One detect item after the baseline subtraction.
	typedef struct packed {
		logic               dev_ok;
		logic [SUM_W-1:0]   dev;
		logic [TAXEL_W-1:0] taxel;
		logic [GROUP_W-1:0] grp;
		logic               last;
	} det_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: rtl/core/tactile_baseline_peak_detect_unit.sv
// Baseline-subtracted peak detector for a tactile hand with five fingers and a palm. Each
// item carries one raw taxel count with its group, its index in the group and an operation:
// store the first baseline frame, add a further baseline frame, or detect. The baseline is
// kept as an exact per-taxel sum (saturating at 21 bits) in a block memory of six groups
// times the slot count rounded up to a power of two. A detect item yields the deviation
// |BASELINE_SAMPLES*sample - sum|, and a single running maximum shared by all groups keeps
// the largest deviation and the first taxel that reached it. A detect item marked last in
// its group produces one report (group, peak, taxel, contact flag, palm region) and clears
// the running maximum. Items with operation 3 or a group above 5 are taken and dropped.
// The block takes one item per clock cycle while in_ready is high. A report passes the
// baseline read stage and the queue, after which it waits in the output register until
// it is taken. Input stalls only when the report output is held back long enough to fill
// the two-entry queue between the baseline stage and the peak tracker.
// The memory holds no reset value; a detect on a taxel that no baseline item wrote reads
// whatever the memory holds. The contact threshold is written through cfg_we/cfg_wdata in
// raw counts; the user must write it while the block is idle, as the block does not enforce it.
`include "assert_macros.svh"

module tactile_baseline_peak_detect_unit
	import tbpd_pkg::*;
#(
	parameter int BASELINE_SAMPLES = 20,
	parameter int GROUP_SLOTS      = 64,
	parameter int PALM_UPPER_COUNT = 20,
	parameter int PALM_LOWER_COUNT = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [GROUP_W-1:0]  group,
	input  logic [TAXEL_W-1:0]  taxel_index,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last_in_group,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [GROUP_W-1:0]  result_group,
	output logic [SUM_W-1:0]    peak_deviation_x20,
	output logic [TAXEL_W-1:0]  peak_index,
	output logic                contact,
	output logic [REGION_W-1:0] region
);

	// Detect items travel from the baseline stage to the peak tracker through the queue.
	logic    push_valid;
	det_t    push_data;
	det_t    pop_data;
	logic    pop;
	q_stat_t q_stat;

	tbpd_front #(
		.BASELINE_SAMPLES(BASELINE_SAMPLES),
		.GROUP_SLOTS     (GROUP_SLOTS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.group        (group),
		.taxel_index  (taxel_index),
		.sample       (sample),
		.last_in_group(last_in_group),
		.push_valid   (push_valid),
		.push_ready   (!q_stat.full),
		.push_data    (push_data)
	);

	tbpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	tbpd_back #(
		.BASELINE_SAMPLES(BASELINE_SAMPLES),
		.PALM_UPPER_COUNT(PALM_UPPER_COUNT),
		.PALM_LOWER_COUNT(PALM_LOWER_COUNT)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.q_valid           (!q_stat.empty),
		.q_data            (pop_data),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_group      (result_group),
		.peak_deviation_x20(peak_deviation_x20),
		.peak_index        (peak_index),
		.contact           (contact),
		.region            (region)
	);

	// The input side may only stall because the queue toward the peak tracker is full.
	`ASSERT_IMPLY(a_stall_only_on_full, !in_ready, q_stat.full, "input stalled with queue room")
	// A zero peak never names a taxel, since the index moves only on a strict increase.
	`ASSERT_IMPLY(a_zero_peak_index, out_valid && peak_deviation_x20 == '0, peak_index == '0,
		"nonzero taxel reported with zero peak")
	// Reported taxels always lie inside the group.
	`ASSERT_IMPLY(a_taxel_in_range, out_valid,
		{1'b0, peak_index} < (TAXEL_W + 1)'(GROUP_SLOTS), "reported taxel beyond group")
	// Finger reports always carry the finger region.
	`ASSERT_IMPLY(a_finger_region, out_valid && result_group != PALM_GROUP,
		region == REGION_FINGER, "finger report with palm region")

endmodule

FILE: rtl/core/tbpd_front.sv
module tbpd_front
	import tbpd_pkg::*;
#(
	parameter int BASELINE_SAMPLES = 20,
	parameter int GROUP_SLOTS      = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [GROUP_W-1:0]  group,
	input  logic [TAXEL_W-1:0]  taxel_index,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                last_in_group,
	output logic                push_valid,
	input  logic                push_ready,
	output det_t                push_data
);

	localparam int SLOT_W    = $clog2(GROUP_SLOTS);
	localparam int ADDR_W    = GROUP_W + SLOT_W;
	localparam int MEM_DEPTH = GROUP_COUNT << SLOT_W;

	logic [SUM_W-1:0] base_mem [MEM_DEPTH];

	logic                in_fire;
	logic                keep;
	logic                tax_ok;
	logic [ADDR_W-1:0]   in_addr;

	logic                valid_s1;
	logic [OP_W-1:0]     op_s1;
	logic [GROUP_W-1:0]  grp_s1;
	logic [TAXEL_W-1:0]  tax_s1;
	logic                taxok_s1;
	logic [SAMPLE_W-1:0] smp_s1;
	logic [SUM_W-1:0]    scaled_s1;
	logic                last_s1;
	logic [ADDR_W-1:0]   addr_s1;
	logic [SUM_W-1:0]    rdata_s1;

	logic                last_wr_valid_q;
	logic [ADDR_W-1:0]   last_wr_addr_q;
	logic [SUM_W-1:0]    last_wr_data_q;

	logic [SUM_W-1:0]    base;
	logic [SUM_W:0]      acc;
	logic [SUM_W-1:0]    new_sum;
	logic                wr_en;
	logic                s1_adv;

	assign in_fire = in_valid && in_ready;
	assign keep    = (group < GROUP_W'(GROUP_COUNT)) && (operation != OP_IGNORED);
	assign tax_ok  = {1'b0, taxel_index} < (TAXEL_W + 1)'(GROUP_SLOTS);
	assign in_addr = {group, taxel_index[SLOT_W-1:0]};

	// The memory read is registered alongside the stage; the write of the item just ahead
	// may land on the same edge as that read, so its value is forwarded from a side register.
	assign base = (last_wr_valid_q && last_wr_addr_q == addr_s1) ? last_wr_data_q : rdata_s1;
	assign acc  = {1'b0, base} + (SUM_W + 1)'(smp_s1);

	always_comb begin
		if (op_s1 == OP_BASE_FIRST) begin
			new_sum = SUM_W'(smp_s1);
		end else if (acc[SUM_W]) begin
			new_sum = '1;
		end else begin
			new_sum = acc[SUM_W-1:0];
		end
	end

	assign wr_en      = valid_s1 && (op_s1 != OP_DETECT) && taxok_s1;
	assign push_valid = valid_s1 && (op_s1 == OP_DETECT) && (taxok_s1 || last_s1);
	assign s1_adv     = valid_s1 && (!push_valid || push_ready);
	assign in_ready   = !valid_s1 || s1_adv;

	assign push_data.dev_ok = taxok_s1;
	assign push_data.dev    = (scaled_s1 >= base) ? (scaled_s1 - base) : (base - scaled_s1);
	assign push_data.taxel  = tax_s1;
	assign push_data.grp    = grp_s1;
	assign push_data.last   = last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			last_wr_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= keep;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (wr_en) begin
				last_wr_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1     <= operation;
			grp_s1    <= group;
			tax_s1    <= taxel_index;
			taxok_s1  <= tax_ok;
			smp_s1    <= sample;
			scaled_s1 <= SUM_W'(BASELINE_SAMPLES) * SUM_W'(sample);
			last_s1   <= last_in_group;
			addr_s1   <= in_addr;
		end
		if (wr_en) begin
			last_wr_addr_q <= addr_s1;
			last_wr_data_q <= new_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			base_mem[addr_s1] <= new_sum;
		end
		if (in_fire && keep) begin
			rdata_s1 <= base_mem[in_addr];
		end
	end

endmodule

FILE: rtl/core/tbpd_queue.sv
module tbpd_queue
	import tbpd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	input  det_t    push_data,
	input  logic    pop,
	output det_t    pop_data,
	output q_stat_t stat
);

	localparam int PTR_W = $clog2(Q_DEPTH);

	det_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             push;

	assign stat.full  = (count_q == (PTR_W + 1)'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign push       = push_valid && !stat.full;
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: rtl/core/tbpd_back.sv
module tbpd_back
	import tbpd_pkg::*;
#(
	parameter int BASELINE_SAMPLES = 20,
	parameter int PALM_UPPER_COUNT = 20,
	parameter int PALM_LOWER_COUNT = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	input  logic                q_valid,
	input  det_t                q_data,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [GROUP_W-1:0]  result_group,
	output logic [SUM_W-1:0]    peak_deviation_x20,
	output logic [TAXEL_W-1:0]  peak_index,
	output logic                contact,
	output logic [REGION_W-1:0] region
);

	localparam logic [TAXEL_W:0] UPPER_END = (TAXEL_W + 1)'(PALM_UPPER_COUNT);
	localparam logic [TAXEL_W:0] LOWER_END = (TAXEL_W + 1)'(PALM_UPPER_COUNT + PALM_LOWER_COUNT);

	function automatic logic [REGION_W-1:0] palm_region(input logic [TAXEL_W-1:0] idx);
		logic [TAXEL_W:0] wide;
		wide = {1'b0, idx};
		if (wide < UPPER_END) begin
			return REGION_PALM_UPPER;
		end else if (wide < LOWER_END) begin
			return REGION_PALM_LOWER;
		end
		return REGION_PALM2;
	endfunction

	logic [SUM_W-1:0]   limit_q;
	logic [SUM_W-1:0]   peak_q;
	logic [TAXEL_W-1:0] idx_q;
	logic               out_valid_q;

	logic               dev_wins;
	logic [SUM_W-1:0]   new_peak;
	logic [TAXEL_W-1:0] new_idx;
	logic               new_contact;

	// Both limit compares run in parallel and the winner of the peak compare picks one.
	assign dev_wins    = q_data.dev_ok && (q_data.dev > peak_q);
	assign new_peak    = dev_wins ? q_data.dev : peak_q;
	assign new_idx     = dev_wins ? q_data.taxel : idx_q;
	assign new_contact = dev_wins ? (q_data.dev > limit_q) : (peak_q > limit_q);

	assign pop       = q_valid && (!q_data.last || !out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= SUM_W'(BASELINE_SAMPLES * THRESH_RESET);
			peak_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= SUM_W'(BASELINE_SAMPLES) * SUM_W'(cfg_wdata);
			end
			if (pop && q_data.last) begin
				peak_q      <= '0;
				idx_q       <= '0;
				out_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					peak_q <= new_peak;
					idx_q  <= new_idx;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_data.last) begin
			result_group       <= q_data.grp;
			peak_deviation_x20 <= new_peak;
			peak_index         <= new_idx;
			contact            <= new_contact;
			region             <= (q_data.grp == PALM_GROUP) ? palm_region(new_idx) : REGION_FINGER;
		end
	end

endmodule
